@@ src/mlq_pkg.sv @@
// Shared types and constants for the multilevel FIFO queue.
// Holds field widths, command and status codes, FSM states and the
// control/status structs between controller and datapath. No dependencies.
package mlq_pkg;

  localparam int CMD_W  = 2;
  localparam int LVL_W  = 2;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int LEN_W  = 5;
  localparam int CFG_W  = 3;

  localparam logic [CFG_W-1:0] LVL_CNT_RST = 3'd4;

  localparam logic [CMD_W-1:0] CMD_ENQ = 2'd0;
  localparam logic [CMD_W-1:0] CMD_DEQ = 2'd1;
  localparam logic [CMD_W-1:0] CMD_LEN = 2'd2;

  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_BAD   = 2'd1;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESP
  } state_t;

  typedef struct packed {
    logic load_in;
    logic exec;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_busy;
  } dp_stat_t;

endpackage

@@ src/mlq_ifs.sv @@
// Valid/ready channel interfaces for the multilevel FIFO queue:
// request, response and configuration write. Depends on mlq_pkg.
interface mlq_in_if;
  import mlq_pkg::*;
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [LVL_W-1:0]  level;
  logic [DATA_W-1:0] item_value;
  modport source (output valid, command, level, item_value, input ready);
  modport sink   (input valid, command, level, item_value, output ready);
endinterface

interface mlq_out_if;
  import mlq_pkg::*;
  logic              valid;
  logic              ready;
  logic [STAT_W-1:0] status;
  logic [LVL_W-1:0]  found_level;
  logic [DATA_W-1:0] item_out;
  logic [LEN_W-1:0]  length;
  modport source (output valid, status, found_level, item_out, length, input ready);
  modport sink   (input valid, status, found_level, item_out, length, output ready);
endinterface

interface mlq_cfg_if;
  import mlq_pkg::*;
  logic             valid;
  logic             ready;
  logic [CFG_W-1:0] data;
  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

@@ src/mlq_ctrl.sv @@
// Controller FSM of the multilevel FIFO queue: sequences accept, execute
// and response load. Depends on mlq_pkg.
module mlq_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  mlq_pkg::dp_stat_t  stat,
  output mlq_pkg::ctrl_cmd_t cmd
);
  import mlq_pkg::*;

  state_t state_r, state_nxt;
  logic   accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_ready  = 1'b0;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        cmd.exec  = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        // hand off the result and take the next request in the same cycle
        if (!stat.out_busy) begin
          cmd.load_out = 1'b1;
          in_ready     = 1'b1;
          state_nxt    = in_valid ? S_EXEC : S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    accept      = in_valid && in_ready;
    cmd.load_in = accept;
  end

endmodule

@@ src/mlq_dpath.sv @@
// Datapath of the multilevel FIFO queue: level register, per-level head and
// count, rotating non-empty pick, entry memory and output register.
// Depends on mlq_pkg.
module mlq_dpath #(
  parameter int MAX_LEVELS = 4,
  parameter int DEPTH      = 16,
  parameter int ITEM_WIDTH = 32
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  mlq_pkg::ctrl_cmd_t         cmd,
  output mlq_pkg::dp_stat_t          stat,
  input  logic [mlq_pkg::CMD_W-1:0]  in_command,
  input  logic [mlq_pkg::LVL_W-1:0]  in_level,
  input  logic [mlq_pkg::DATA_W-1:0] in_item_value,
  input  logic                       cfg_valid,
  input  logic [mlq_pkg::CFG_W-1:0]  cfg_data,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [mlq_pkg::STAT_W-1:0] out_status,
  output logic [mlq_pkg::LVL_W-1:0]  out_found_level,
  output logic [mlq_pkg::DATA_W-1:0] out_item_out,
  output logic [mlq_pkg::LEN_W-1:0]  out_length
);
  import mlq_pkg::*;

  localparam int CfgMax  = (1 << CFG_W) - 1;
  localparam int LvlLim  = (MAX_LEVELS < CfgMax) ? MAX_LEVELS : CfgMax;
  localparam int LIW     = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int HW      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW      = $clog2(DEPTH + 1);
  localparam int Entries = MAX_LEVELS * DEPTH;
  localparam int AW      = (Entries > 1) ? $clog2(Entries) : 1;

  logic [CFG_W-1:0]      level_count_r;
  logic [CMD_W-1:0]      cmd_r;
  logic [LVL_W-1:0]      lvl_r;
  logic [ITEM_WIDTH-1:0] item_r;
  logic [HW-1:0]         head_r  [MAX_LEVELS];
  logic [CW-1:0]         count_r [MAX_LEVELS];
  logic [ITEM_WIDTH-1:0] mem     [Entries];
  logic [ITEM_WIDTH-1:0] rd_r;
  logic [STAT_W-1:0]     status_r;
  logic [LVL_W-1:0]      found_r;
  logic [LEN_W-1:0]      len_r;
  logic                  deq_ok_r;
  logic                  out_valid_r;
  logic [STAT_W-1:0]     out_status_r;
  logic [LVL_W-1:0]      out_found_r;
  logic [DATA_W-1:0]     out_item_r;
  logic [LEN_W-1:0]      out_len_r;

  logic [CFG_W-1:0]      n_lvl;
  logic                  bad;
  logic [MAX_LEVELS-1:0] nonempty;
  logic                  found;
  logic [LIW-1:0]        pick_q;
  logic [LIW-1:0]        tgt;
  logic [HW-1:0]         head_t;
  logic [CW-1:0]         cnt_t;
  logic [CW:0]           tail_sum;
  logic [HW-1:0]         slot;
  logic [AW-1:0]         addr;
  logic                  enq_ok;
  logic                  deq_ok;
  logic [STAT_W-1:0]     status_nxt;
  logic [LVL_W-1:0]      found_nxt;
  logic [LEN_W-1:0]      len_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_count_r <= LVL_CNT_RST;
    end else if (cfg_valid) begin
      level_count_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      cmd_r  <= in_command;
      lvl_r  <= in_level;
      item_r <= ITEM_WIDTH'(in_item_value);
    end
  end

  always_comb begin
    n_lvl = (int'(level_count_r) > LvlLim) ? CFG_W'(LvlLim) : level_count_r;
    bad   = (cmd_r != CMD_ENQ && cmd_r != CMD_DEQ && cmd_r != CMD_LEN) ||
            (n_lvl == '0) || (CFG_W'(lvl_r) >= n_lvl);
    for (int i = 0; i < MAX_LEVELS; i++) begin
      nonempty[i] = (count_r[i] != '0);
    end
  end

  // Rotating pick: first non-empty level at or after the start, wrapping at n.
  always_comb begin
    logic [CFG_W:0] qk;
    found  = 1'b0;
    pick_q = '0;
    for (int k = LvlLim - 1; k >= 0; k--) begin
      qk = (CFG_W + 1)'(lvl_r) + (CFG_W + 1)'(k);
      if (qk >= (CFG_W + 1)'(n_lvl)) begin
        qk = qk - (CFG_W + 1)'(n_lvl);
      end
      if (k < int'(n_lvl)) begin
        if (nonempty[LIW'(qk)]) begin
          found  = 1'b1;
          pick_q = LIW'(qk);
        end
      end
    end
  end

  always_comb begin
    tgt      = (cmd_r == CMD_DEQ) ? pick_q : LIW'(lvl_r);
    head_t   = head_r[tgt];
    cnt_t    = count_r[tgt];
    tail_sum = (CW + 1)'(head_t) + (CW + 1)'(cnt_t);
    if (tail_sum >= (CW + 1)'(DEPTH)) begin
      tail_sum = tail_sum - (CW + 1)'(DEPTH);
    end
    slot   = (cmd_r == CMD_DEQ) ? head_t : HW'(tail_sum);
    addr   = AW'(int'(tgt) * DEPTH + int'(slot));
    enq_ok = !bad && (cmd_r == CMD_ENQ) && (item_r != '0) && (cnt_t < CW'(DEPTH));
    deq_ok = !bad && (cmd_r == CMD_DEQ) && found;

    status_nxt = ST_OK;
    found_nxt  = '0;
    len_nxt    = '0;
    if (bad) begin
      status_nxt = ST_BAD;
    end else begin
      case (cmd_r)
        CMD_ENQ: begin
          if (item_r == '0) begin
            status_nxt = ST_BAD;
          end else if (!enq_ok) begin
            status_nxt = ST_FULL;
          end
        end
        CMD_DEQ: begin
          if (found) begin
            found_nxt = LVL_W'(pick_q);
          end else begin
            status_nxt = ST_EMPTY;
          end
        end
        CMD_LEN: begin
          len_nxt = LEN_W'(cnt_t);
        end
        default: begin
          status_nxt = ST_BAD;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      if (enq_ok) begin
        mem[addr] <= item_r;
      end
      rd_r <= mem[addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        head_r[i]  <= '0;
        count_r[i] <= '0;
      end
    end else if (cmd.exec) begin
      if (enq_ok) begin
        count_r[tgt] <= cnt_t + CW'(1);
      end else if (deq_ok) begin
        count_r[tgt] <= cnt_t - CW'(1);
        head_r[tgt]  <= (head_t == HW'(DEPTH - 1)) ? '0 : head_t + HW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status_r <= status_nxt;
      found_r  <= found_nxt;
      len_r    <= len_nxt;
      deq_ok_r <= deq_ok;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= status_r;
      out_found_r  <= found_r;
      out_item_r   <= deq_ok_r ? DATA_W'(rd_r) : '0;
      out_len_r    <= len_r;
    end
  end

  assign stat.out_busy   = out_valid_r && !out_ready;
  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_level = out_found_r;
  assign out_item_out    = out_item_r;
  assign out_length      = out_len_r;

endmodule

@@ src/multilevel_fifo_queue_core.sv @@
// Top level of the multilevel FIFO queue: one FIFO per priority level.
// Depends on mlq_pkg, the channel interfaces, mlq_ctrl and mlq_dpath.
//
// Usage:
//   in_req  : request channel (command, level, item_value); a request is taken
//             when valid and ready are both high at a rising clk edge.
//   out_rsp : one response per request (status, found_level, item_out, length).
//   cfg_wr  : write of level_count, always ready; write only while idle.
// Timing: a request is taken, executed in the next cycle (one entry memory
//   access plus the rotating pick over the non-empty flags), and its
//   response goes via S_RESP into the output register once that register is
//   free. A new request is taken in the same cycle as that load, so a new
//   request is only taken after the previous one has been executed.
// Stall: while a response sits unconsumed in the output register, the next
//   request is still taken and executed; it then waits until the output
//   register frees up, and in_req.ready stays low meanwhile.
// Reset (rst_n low, synchronous): all levels empty, heads at zero,
//   level_count = 4. Entry memory is not cleared; only written slots reach item_out.
module multilevel_fifo_queue_core #(
  parameter int MAX_LEVELS = 4,
  parameter int DEPTH      = 16,
  parameter int ITEM_WIDTH = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  mlq_in_if.sink    in_req,
  mlq_out_if.source out_rsp,
  mlq_cfg_if.sink   cfg_wr
);
  import mlq_pkg::*;

  ctrl_cmd_t ctl_cmd;
  dp_stat_t  dp_stat;

  // configuration writes are registered directly and never stall
  assign cfg_wr.ready = 1'b1;

  mlq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_req.valid),
    .in_ready (in_req.ready),
    .stat     (dp_stat),
    .cmd      (ctl_cmd)
  );

  mlq_dpath #(
    .MAX_LEVELS (MAX_LEVELS),
    .DEPTH      (DEPTH),
    .ITEM_WIDTH (ITEM_WIDTH)
  ) u_dpath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (ctl_cmd),
    .stat            (dp_stat),
    .in_command      (in_req.command),
    .in_level        (in_req.level),
    .in_item_value   (in_req.item_value),
    .cfg_valid       (cfg_wr.valid),
    .cfg_data        (cfg_wr.data),
    .out_valid       (out_rsp.valid),
    .out_ready       (out_rsp.ready),
    .out_status      (out_rsp.status),
    .out_found_level (out_rsp.found_level),
    .out_item_out    (out_rsp.item_out),
    .out_length      (out_rsp.length)
  );

  // every taken request is executed in the very next cycle
  a_exec_follows: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.load_in |=> ctl_cmd.exec)
    else $error("request taken without execute cycle");

  // no request is taken while one is being executed
  a_no_take_in_exec: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.exec |-> !in_req.ready)
    else $error("request taken during execute");

  // a failed response carries no item and no level
  a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_rsp.valid && out_rsp.status != ST_OK) |->
      (out_rsp.item_out == '0 && out_rsp.found_level == '0 && out_rsp.length == '0))
    else $error("failed response with payload");

  // the output register is only reloaded once it is free
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_cmd.load_out |-> (!out_rsp.valid || out_rsp.ready))
    else $error("response overwritten");

endmodule
